FILE: hdl/agl_pkg.sv
// Shared types, constants and helper functions of the aging Life generation step.
// Used by every module of the block but agl_ram; depends on nothing else.
`default_nettype none

package agl_pkg;

   // Field and register widths fixed by the interface.
   localparam int AGE_W       = 8;
   localparam int POS_W       = 10;
   localparam int TOTAL_W     = 28;
   localparam int DIM_W       = 11;
   localparam int MAX_AGE_W   = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W     = 5;

   // Default field size limits and register reset values.
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;
   localparam int DIM_RESET          = 1024;
   localparam int DIM_MIN            = 3;
   localparam int MAX_AGE_RESET      = 64;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Side of the neighbourhood window and first row and column of cells that yield a result.
   localparam int WINDOW_DIM   = 3;
   localparam int BORDER_CELLS = 2;

   // Life rule constants.
   localparam int SURVIVE_COUNT_LO = 2;
   localparam int BIRTH_COUNT      = 3;
   localparam int BORN_AGE         = 1;

   // Neighbour weights.
   localparam logic [1:0] WEIGHT_DEAD  = 2'd0;
   localparam logic [1:0] WEIGHT_YOUNG = 2'd1;
   localparam logic [1:0] WEIGHT_OLD   = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_AGE      = 2'd2;

   // One cell as it travels from the front to the back.
   typedef struct packed {
      logic [AGE_W-1:0] upper;
      logic [AGE_W-1:0] middle;
      logic [AGE_W-1:0] lower;
      logic             sum_clear;
      logic             emit;
      logic             last_cell;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
   } cell_item_type;

   function automatic logic [1:0] neighbour_weight(input logic [AGE_W-1:0] age,
                                                   input logic [MAX_AGE_W-1:0] max_age);
      logic [1:0] weight;
      if (age == '0) begin
         weight = WEIGHT_DEAD;
      end else if ({1'b0, age} > max_age) begin
         weight = WEIGHT_OLD;
      end else begin
         weight = WEIGHT_YOUNG;
      end
      return weight;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/agl_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Read-first on a same-address collision. Depends on nothing else.
`default_nettype none

module agl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/agl_queue.sv
// Short first-in first-out queue of cells between the front and the back.
// Depends on agl_pkg for the cell item type.
`default_nettype none

module agl_queue #(
   parameter int DEPTH = agl_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire agl_pkg::cell_item_type push_item,
   output logic                        full,
   input  wire logic                   pop,
   output agl_pkg::cell_item_type      head_item,
   output logic                        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   agl_pkg::cell_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: hdl/agl_front.sv
// Front of the block: accepts cells, tracks the raster position, reads and
// updates the two-line store and classifies each cell. Uses agl_pkg and agl_ram.
`default_nettype none

module agl_front #(
   parameter int MAX_WIDTH  = agl_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = agl_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [agl_pkg::AGE_W-1:0]          req_cell_age,
   input  wire logic [$clog2(MAX_WIDTH + 1)-1:0]   field_width,
   input  wire logic [$clog2(MAX_HEIGHT + 1)-1:0]  field_height,
   input  wire logic                               queue_full,
   output logic                                    queue_push,
   output agl_pkg::cell_item_type                  queue_item
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int AGE_W = agl_pkg::AGE_W;
   localparam int POS_W = agl_pkg::POS_W;

   // Position of the next cell, already wrapped against the field in use.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          clear_pend_ff, clear_pend_in;

   // Second stage: waits for the line store read data.
   logic             s2_valid_ff, s2_valid_in;
   logic [AGE_W-1:0] s2_age_ff;
   logic [AW-1:0]    s2_addr_ff;
   logic [POS_W-1:0] s2_column_ff;
   logic [POS_W-1:0] s2_row_ff;
   logic             s2_clear_ff;
   logic             s2_emit_ff;
   logic             s2_last_ff;

   logic             accept;
   logic [CW-1:0]    cur_col;
   logic [RW-1:0]    row_b;
   logic [RW-1:0]    cur_row;
   logic             pre_clear;
   logic             emit;
   logic             last_cell;
   logic             post_clear;
   logic [2*AGE_W-1:0] line_rd_data;

   assign req_stall  = s2_valid_ff && queue_full;
   assign accept     = req_valid && !req_stall;
   assign queue_push = s2_valid_ff && !queue_full;

   // Wrap the stored position first, because the field size may have been
   // changed since the last cell; then work out the position after this cell.
   always_comb begin
      cur_col   = col_ff;
      row_b     = row_ff;
      if (col_ff >= field_width) begin
         cur_col = '0;
         row_b   = row_ff + RW'(1);
      end
      cur_row   = row_b;
      pre_clear = 1'b0;
      if (row_b >= field_height) begin
         cur_row   = '0;
         pre_clear = 1'b1;
      end

      emit      = (cur_row >= RW'(agl_pkg::BORDER_CELLS)) &&
                  (cur_col >= CW'(agl_pkg::BORDER_CELLS));
      last_cell = emit && (cur_row == field_height - RW'(1)) &&
                  (cur_col == field_width - CW'(1));

      col_in     = cur_col + CW'(1);
      row_in     = cur_row;
      post_clear = 1'b0;
      if (col_in >= field_width) begin
         col_in = '0;
         row_in = cur_row + RW'(1);
      end
      if (row_in >= field_height) begin
         row_in     = '0;
         post_clear = 1'b1;
      end
      clear_pend_in = post_clear;
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (accept) begin
         s2_valid_in = 1'b1;
      end else if (queue_push) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         clear_pend_ff <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            col_ff        <= col_in;
            row_ff        <= row_in;
            clear_pend_ff <= clear_pend_in;
         end
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s2_age_ff    <= req_cell_age;
         s2_addr_ff   <= cur_col[AW-1:0];
         s2_column_ff <= POS_W'(32'(cur_col) - 32'd1);
         s2_row_ff    <= POS_W'(32'(cur_row) - 32'd1);
         s2_clear_ff  <= pre_clear || clear_pend_ff;
         s2_emit_ff   <= emit;
         s2_last_ff   <= last_cell;
      end
   end

   // Each entry holds the upper line in the high byte and the middle line in
   // the low byte. The entry moves up one line once its old value is known.
   agl_ram #(
      .WIDTH (2 * AGE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (queue_push),
      .wr_addr (s2_addr_ff),
      .wr_data ({line_rd_data[AGE_W-1:0], s2_age_ff}),
      .rd_en   (accept),
      .rd_addr (cur_col[AW-1:0]),
      .rd_data (line_rd_data)
   );

   always_comb begin
      queue_item.upper     = line_rd_data[2*AGE_W-1:AGE_W];
      queue_item.middle    = line_rd_data[AGE_W-1:0];
      queue_item.lower     = s2_age_ff;
      queue_item.sum_clear = s2_clear_ff;
      queue_item.emit      = s2_emit_ff;
      queue_item.last_cell = s2_last_ff;
      queue_item.column    = s2_column_ff;
      queue_item.row       = s2_row_ff;
   end

endmodule

`default_nettype wire

FILE: hdl/agl_back.sv
// Back of the block: shifts the 3x3 window, counts weighted neighbours,
// applies the aging Life rule and keeps the running age total. Uses agl_pkg.
`default_nettype none

module agl_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [agl_pkg::MAX_AGE_W-1:0]     max_age,
   input  wire logic                              queue_empty,
   output logic                                   queue_pop,
   input  wire agl_pkg::cell_item_type            queue_item,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [agl_pkg::AGE_W-1:0]              rsp_new_age,
   output logic [agl_pkg::POS_W-1:0]              rsp_column,
   output logic [agl_pkg::POS_W-1:0]              rsp_row,
   output logic [agl_pkg::TOTAL_W-1:0]            rsp_age_total,
   output logic                                   rsp_last_cell
);

   localparam int AGE_W   = agl_pkg::AGE_W;
   localparam int POS_W   = agl_pkg::POS_W;
   localparam int TOTAL_W = agl_pkg::TOTAL_W;
   localparam int COUNT_W = agl_pkg::COUNT_W;
   localparam int WD      = agl_pkg::WINDOW_DIM;

   // Window stage.
   logic             a_valid_ff;
   logic [AGE_W-1:0] win_ff [WD][WD];
   logic             a_clear_ff, a_emit_ff, a_last_ff;
   logic [POS_W-1:0] a_column_ff, a_row_ff;

   // Count stage.
   logic               b_valid_ff;
   logic [COUNT_W-1:0] b_count_ff;
   logic [AGE_W-1:0]   b_centre_ff;
   logic               b_clear_ff, b_emit_ff, b_last_ff;
   logic [POS_W-1:0]   b_column_ff, b_row_ff;

   // Result register and running total.
   logic               rsp_valid_ff;
   logic [AGE_W-1:0]   rsp_new_age_ff;
   logic [POS_W-1:0]   rsp_column_ff, rsp_row_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_last_ff;
   logic [TOTAL_W-1:0] sum_ff, sum_in;

   logic               out_free, b_move, b_load;
   logic [COUNT_W-1:0] count;
   logic [AGE_W-1:0]   next_age;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign b_move    = b_valid_ff && (!b_emit_ff || out_free);
   assign b_load    = a_valid_ff && (!b_valid_ff || b_move);
   assign queue_pop = !queue_empty && (!a_valid_ff || b_load);

   // Weighted neighbour count of the window centre.
   always_comb begin
      count = '0;
      for (int i = 0; i < WD; i++) begin
         for (int j = 0; j < WD; j++) begin
            if (!(i == 1 && j == 1)) begin
               count = count + COUNT_W'(agl_pkg::neighbour_weight(win_ff[i][j], max_age));
            end
         end
      end
   end

   always_comb begin
      next_age = '0;
      if (b_centre_ff != '0) begin
         if (b_count_ff == COUNT_W'(agl_pkg::SURVIVE_COUNT_LO) ||
             b_count_ff == COUNT_W'(agl_pkg::BIRTH_COUNT)) begin
            next_age = b_centre_ff + AGE_W'(1);
         end
      end else if (b_count_ff == COUNT_W'(agl_pkg::BIRTH_COUNT)) begin
         next_age = AGE_W'(agl_pkg::BORN_AGE);
      end
      sum_in = (b_clear_ff ? '0 : sum_ff) + (b_emit_ff ? TOTAL_W'(next_age) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         for (int i = 0; i < WD; i++) begin
            for (int j = 0; j < WD; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         if (queue_pop) begin
            a_valid_ff <= 1'b1;
            for (int i = 0; i < WD; i++) begin
               for (int j = 0; j < WD - 1; j++) begin
                  win_ff[i][j] <= win_ff[i][j+1];
               end
            end
            win_ff[0][WD-1] <= queue_item.upper;
            win_ff[1][WD-1] <= queue_item.middle;
            win_ff[2][WD-1] <= queue_item.lower;
         end else if (b_load) begin
            a_valid_ff <= 1'b0;
         end

         if (b_load) begin
            b_valid_ff <= 1'b1;
         end else if (b_move) begin
            b_valid_ff <= 1'b0;
         end

         if (b_move) begin
            sum_ff <= sum_in;
         end

         if (b_move && b_emit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         a_clear_ff  <= queue_item.sum_clear;
         a_emit_ff   <= queue_item.emit;
         a_last_ff   <= queue_item.last_cell;
         a_column_ff <= queue_item.column;
         a_row_ff    <= queue_item.row;
      end
      if (b_load) begin
         b_count_ff  <= count;
         b_centre_ff <= win_ff[1][1];
         b_clear_ff  <= a_clear_ff;
         b_emit_ff   <= a_emit_ff;
         b_last_ff   <= a_last_ff;
         b_column_ff <= a_column_ff;
         b_row_ff    <= a_row_ff;
      end
      if (b_move && b_emit_ff) begin
         rsp_new_age_ff <= next_age;
         rsp_column_ff  <= b_column_ff;
         rsp_row_ff     <= b_row_ff;
         rsp_total_ff   <= sum_in;
         rsp_last_ff    <= b_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_age   = rsp_new_age_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_age_total = rsp_total_ff;
   assign rsp_last_cell = rsp_last_ff;

endmodule

`default_nettype wire

FILE: hdl/aging_life_generation_step_top.sv
// Top level of the aging Life generation step: configuration registers and
// the front, queue and back. Uses agl_pkg, agl_front, agl_queue and agl_back.
//
// Usage: cells of one generation arrive in raster order on the req_ channel,
// one 8-bit age per transaction, the one-cell border included. A transaction
// takes place at a rising edge where valid is high and stall is low. For each
// interior cell the rsp_ channel gives one transaction with the cell's next
// age, its interior column and row, the running sum of new ages in this
// generation and a flag on the generation's final interior cell. Border cells
// give no result.
// The block takes one cell per clock cycle, back to back, while results are
// taken as fast. A cell passes through the line store read, the queue, the
// window, the neighbour count and the result register before its result
// appears. The line store read port sets the rate.
// When the receiver stalls, the result register holds its value, the queue
// between front and back fills, and req_stall rises only once it is full.
// Reset clears the position, the running sum, the window and all valid
// flags and restores the registers to width 1024, height 1024 (clamped to
// MAX_WIDTH and MAX_HEIGHT) and max age 64. The line stores are not cleared;
// every entry is written by the first row before the rows below read it.
// The csr_ port is always ready; widths and heights are clamped when written.
`default_nettype none

module aging_life_generation_step_top #(
   parameter int MAX_WIDTH  = agl_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = agl_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [agl_pkg::AGE_W-1:0]          req_cell_age,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [agl_pkg::AGE_W-1:0]               rsp_new_age,
   output logic [agl_pkg::POS_W-1:0]               rsp_column,
   output logic [agl_pkg::POS_W-1:0]               rsp_row,
   output logic [agl_pkg::TOTAL_W-1:0]             rsp_age_total,
   output logic                                    rsp_last_cell,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [agl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [agl_pkg::DIM_W-1:0]          csr_data
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int WIDTH_RESET  = (agl_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                  : agl_pkg::DIM_RESET;
   localparam int HEIGHT_RESET = (agl_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                   : agl_pkg::DIM_RESET;

   // Registers hold the clamped field size, which is all the logic ever uses.
   logic [CW-1:0]                   width_ff, width_in;
   logic [RW-1:0]                   height_ff, height_in;
   logic [agl_pkg::MAX_AGE_W-1:0]   max_age_ff, max_age_in;
   logic                            csr_write;

   logic                   queue_full, queue_empty, queue_push, queue_pop;
   agl_pkg::cell_item_type push_item, head_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      max_age_in = max_age_ff;
      if (csr_write) begin
         unique case (csr_index)
            agl_pkg::CSR_FIELD_WIDTH: begin
               if (csr_data < agl_pkg::DIM_W'(agl_pkg::DIM_MIN)) begin
                  width_in = CW'(agl_pkg::DIM_MIN);
               end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
                  width_in = CW'(MAX_WIDTH);
               end else begin
                  width_in = CW'(csr_data);
               end
            end
            agl_pkg::CSR_FIELD_HEIGHT: begin
               if (csr_data < agl_pkg::DIM_W'(agl_pkg::DIM_MIN)) begin
                  height_in = RW'(agl_pkg::DIM_MIN);
               end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
                  height_in = RW'(MAX_HEIGHT);
               end else begin
                  height_in = RW'(csr_data);
               end
            end
            agl_pkg::CSR_MAX_AGE: begin
               max_age_in = csr_data[agl_pkg::MAX_AGE_W-1:0];
            end
            default: begin
               // Writes to an unused index are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CW'(WIDTH_RESET);
         height_ff  <= RW'(HEIGHT_RESET);
         max_age_ff <= agl_pkg::MAX_AGE_W'(agl_pkg::MAX_AGE_RESET);
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         max_age_ff <= max_age_in;
      end
   end

   agl_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cell_age (req_cell_age),
      .field_width  (width_ff),
      .field_height (height_ff),
      .queue_full   (queue_full),
      .queue_push   (queue_push),
      .queue_item   (push_item)
   );

   agl_queue #(
      .DEPTH (agl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_item (head_item),
      .empty     (queue_empty)
   );

   agl_back u_back (
      .clock         (clock),
      .reset         (reset),
      .max_age       (max_age_ff),
      .queue_empty   (queue_empty),
      .queue_pop     (queue_pop),
      .queue_item    (head_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_new_age   (rsp_new_age),
      .rsp_column    (rsp_column),
      .rsp_row       (rsp_row),
      .rsp_age_total (rsp_age_total),
      .rsp_last_cell (rsp_last_cell)
   );

endmodule

`default_nettype wire

FILE: hdl/agl_checker.sv
// Port-level checks on the aging Life generation step, bound to its top level.
// Depends on agl_pkg for field widths.
`default_nettype none

module agl_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [agl_pkg::AGE_W-1:0]     rsp_new_age,
   input wire logic [agl_pkg::POS_W-1:0]     rsp_column,
   input wire logic [agl_pkg::POS_W-1:0]     rsp_row,
   input wire logic [agl_pkg::TOTAL_W-1:0]   rsp_age_total,
   input wire logic                          rsp_last_cell
);

   // No result can be pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid in the cycle after reset");

   // The front is empty after reset, so it must take a cell at once.
   assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled in the cycle after reset");

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_age) &&
         $stable(rsp_column) && $stable(rsp_row) && $stable(rsp_age_total) &&
         $stable(rsp_last_cell))
      else $error("stalled result changed");

endmodule

bind aging_life_generation_step_top agl_checker u_checker (.*);

`default_nettype wire
